// ===== rtl/four_op_register_machine_core_top_macros.svh =====
// Assertion helpers for the four-op register machine core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef FOUR_OP_REGISTER_MACHINE_CORE_TOP_MACROS_SVH
`define FOUR_OP_REGISTER_MACHINE_CORE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FOPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FOPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fopr_pkg.sv =====
// Shared types and constants for the four-op register machine core.
// No dependencies; imported by every module of the block.
`default_nettype none

package fopr_pkg;

  localparam int WORD_W    = 32;
  localparam int INSTR_W   = 16;
  localparam int REG_IDX_W = 4;
  localparam int ADDR_W    = 8;
  localparam int REQ_W     = 2;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  // Opcodes in instruction bits 15:12
  localparam logic [3:0] OPC_ADD   = 4'b0000;
  localparam logic [3:0] OPC_SUB   = 4'b0001;
  localparam logic [3:0] OPC_LOAD  = 4'b1000;
  localparam logic [3:0] OPC_STORE = 4'b1001;

  // Request types
  localparam logic [REQ_W-1:0] REQ_EXEC    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_HOST_WR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_HOST_RD = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_LOAD,
    OP_STORE,
    OP_HOST_WR,
    OP_HOST_RD,
    OP_BAD,
    OP_NONE
  } op_kind_e;

  typedef struct packed {
    op_kind_e              kind;
    logic [REG_IDX_W-1:0]  ra;
    logic [REG_IDX_W-1:0]  rb;
    logic [REG_IDX_W-1:0]  rd;
    logic [ADDR_W-1:0]     maddr;
    logic [WORD_W-1:0]     data;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_slot_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] ra;
    logic [REG_IDX_W-1:0] rb;
  } rf_rd_t;

  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] idx;
    logic [WORD_W-1:0]    data;
  } rf_wr_t;

endpackage

`default_nettype wire

// ===== rtl/fopr_front.sv =====
// Front end: takes requests from the input channel and classifies them
// into queue entries. Depends on fopr_pkg.
`default_nettype none

module fopr_front (
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [fopr_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [fopr_pkg::INSTR_W-1:0]  instr_word_i,
  input  wire logic [fopr_pkg::ADDR_W-1:0]   host_addr_i,
  input  wire logic signed [fopr_pkg::WORD_W-1:0] host_data_i,
  input  wire logic                          q_full_i,
  output fopr_pkg::q_slot_t                  push_o
);
  import fopr_pkg::*;

  op_kind_e kind;

  always_comb begin
    kind = OP_NONE;
    case (req_type_i)
      REQ_EXEC: begin
        case (instr_word_i[15:12])
          OPC_ADD:   kind = OP_ADD;
          OPC_SUB:   kind = OP_SUB;
          OPC_LOAD:  kind = OP_LOAD;
          OPC_STORE: kind = OP_STORE;
          default:   kind = OP_BAD;
        endcase
      end
      REQ_HOST_WR: kind = OP_HOST_WR;
      REQ_HOST_RD: kind = OP_HOST_RD;
      default:     kind = OP_NONE;
    endcase
  end

  assign in_stall_o = q_full_i;

  always_comb begin
    push_o.valid       = in_valid_i && !q_full_i;
    push_o.entry.kind  = kind;
    push_o.entry.ra    = instr_word_i[11:8];
    push_o.entry.rb    = instr_word_i[7:4];
    push_o.entry.rd    = instr_word_i[3:0];
    // host requests carry their own address
    push_o.entry.maddr = (req_type_i == REQ_EXEC) ? instr_word_i[7:0] : host_addr_i;
    push_o.entry.data  = host_data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/fopr_queue.sv =====
// Short FIFO between front end and execute back end.
// Depends on fopr_pkg for entry type and depth.
`default_nettype none

module fopr_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fopr_pkg::q_slot_t push_i,
  input  wire logic              pop_i,
  output logic                   full_o,
  output fopr_pkg::q_slot_t      head_o
);
  import fopr_pkg::*;

  q_entry_t            slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;

  assign full_o       = (count_q == (QPTR_W+1)'(QDEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i.valid ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push_i.valid, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fopr_regfile.sv =====
// Register file with registered two-port read, write-through and
// per-entry valid bits so unwritten registers read as zero. Uses fopr_pkg.
`default_nettype none

module fopr_regfile #(
  parameter int REG_COUNT = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fopr_pkg::rf_rd_t             rd_i,
  input  wire fopr_pkg::rf_wr_t             wr_i,
  output logic [fopr_pkg::WORD_W-1:0]       a_o,
  output logic [fopr_pkg::WORD_W-1:0]       b_o
);
  import fopr_pkg::*;

  localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [REG_IDX_W:0] REG_LIM = (REG_IDX_W+1)'(REG_COUNT);

  logic [WORD_W-1:0]    rf_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [WORD_W-1:0]    a_q, a_d, b_q, b_d;
  logic [RIDX_W-1:0]    ra_s, rb_s, wr_s;
  logic                 ra_ok, rb_ok;

  assign ra_s  = rd_i.ra[RIDX_W-1:0];
  assign rb_s  = rd_i.rb[RIDX_W-1:0];
  assign wr_s  = wr_i.idx[RIDX_W-1:0];
  assign ra_ok = ({1'b0, rd_i.ra} < REG_LIM);
  assign rb_ok = ({1'b0, rd_i.rb} < REG_LIM);

  // write-through so a read in the write cycle sees the new value
  always_comb begin
    if (wr_i.we && (wr_i.idx == rd_i.ra)) begin
      a_d = wr_i.data;
    end else if (ra_ok && vld_q[ra_s]) begin
      a_d = rf_q[ra_s];
    end else begin
      a_d = '0;
    end
    if (wr_i.we && (wr_i.idx == rd_i.rb)) begin
      b_d = wr_i.data;
    end else if (rb_ok && vld_q[rb_s]) begin
      b_d = rf_q[rb_s];
    end else begin
      b_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.we) begin
      vld_q[wr_s] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      rf_q[wr_s] <= wr_i.data;
    end
    if (rd_i.en) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

`default_nettype wire

// ===== rtl/fopr_back.sv =====
// Execute back end: operand stage with forwarding, data memory access,
// result stage that doubles as the output register. Uses fopr_pkg.
`default_nettype none

module fopr_back #(
  parameter int REG_COUNT  = 16,
  parameter int DATA_WORDS = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fopr_pkg::q_slot_t             head_i,
  output logic                               pop_o,
  output fopr_pkg::rf_rd_t                   rf_rd_o,
  output fopr_pkg::rf_wr_t                   rf_wr_o,
  input  wire logic [fopr_pkg::WORD_W-1:0]   rf_a_i,
  input  wire logic [fopr_pkg::WORD_W-1:0]   rf_b_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [fopr_pkg::WORD_W-1:0] result_value_o,
  output logic                               bad_opcode_o
);
  import fopr_pkg::*;

  localparam int MEM_AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam logic [ADDR_W:0]    MEM_LIM = (ADDR_W+1)'(DATA_WORDS);
  localparam logic [REG_IDX_W:0] REG_LIM = (REG_IDX_W+1)'(REG_COUNT);

  // operand stage
  logic     e1_valid_q;
  q_entry_t e1_q;

  // result stage
  logic                 e2_valid_q;
  logic [WORD_W-1:0]    e2_value_q;
  logic                 e2_bad_q;
  logic                 e2_from_mem_q;
  logic                 e2_mem_ok_q;
  logic                 e2_rwe_q;
  logic [REG_IDX_W-1:0] e2_widx_q;

  logic [WORD_W-1:0]    dmem_q [DATA_WORDS];
  logic [WORD_W-1:0]    mem_rdata_q;

  logic                 out_take, e1_adv;
  logic [WORD_W-1:0]    e2_val, op_a, op_b;
  logic                 mem_ok, ra_ok, rd_ok;
  logic [MEM_AW-1:0]    mem_idx;

  // operand-stage outcome
  logic [WORD_W-1:0]    x_value;
  logic                 x_bad, x_from_mem, x_rwe, x_mem_we, x_mem_re;
  logic [REG_IDX_W-1:0] x_widx;

  assign out_take = e2_valid_q && !out_stall_i;
  assign e1_adv   = e1_valid_q && (!e2_valid_q || out_take);
  assign pop_o    = head_i.valid && (!e1_valid_q || e1_adv);

  assign e2_val = e2_from_mem_q ? (e2_mem_ok_q ? mem_rdata_q : '0) : e2_value_q;

  // hold the register write until the result leaves; forward meanwhile
  always_comb begin
    rf_wr_o.we   = out_take && e2_rwe_q;
    rf_wr_o.idx  = e2_widx_q;
    rf_wr_o.data = e2_val;
    rf_rd_o.en   = pop_o;
    rf_rd_o.ra   = head_i.entry.ra;
    rf_rd_o.rb   = head_i.entry.rb;
  end

  assign op_a = (e2_valid_q && e2_rwe_q && (e2_widx_q == e1_q.ra)) ? e2_val : rf_a_i;
  assign op_b = (e2_valid_q && e2_rwe_q && (e2_widx_q == e1_q.rb)) ? e2_val : rf_b_i;

  assign mem_ok  = ({1'b0, e1_q.maddr} < MEM_LIM);
  assign ra_ok   = ({1'b0, e1_q.ra} < REG_LIM);
  assign rd_ok   = ({1'b0, e1_q.rd} < REG_LIM);
  assign mem_idx = e1_q.maddr[MEM_AW-1:0];

  always_comb begin
    x_value    = '0;
    x_bad      = 1'b0;
    x_from_mem = 1'b0;
    x_rwe      = 1'b0;
    x_widx     = e1_q.rd;
    x_mem_we   = 1'b0;
    x_mem_re   = 1'b0;
    case (e1_q.kind)
      OP_ADD: begin
        x_value = op_a + op_b;
        x_rwe   = rd_ok;
      end
      OP_SUB: begin
        x_value = op_a - op_b;
        x_rwe   = rd_ok;
      end
      OP_LOAD: begin
        x_from_mem = 1'b1;
        x_mem_re   = mem_ok;
        x_rwe      = ra_ok;
        x_widx     = e1_q.ra;
      end
      OP_STORE: begin
        x_value  = op_a;
        x_mem_we = mem_ok;
      end
      OP_HOST_WR: begin
        x_value  = e1_q.data;
        x_mem_we = mem_ok;
      end
      OP_HOST_RD: begin
        x_from_mem = 1'b1;
        x_mem_re   = mem_ok;
      end
      OP_BAD:  x_bad = 1'b1;
      default: x_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
      e2_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        e1_valid_q <= 1'b1;
      end else if (e1_adv) begin
        e1_valid_q <= 1'b0;
      end
      if (e1_adv) begin
        e2_valid_q <= 1'b1;
      end else if (out_take) begin
        e2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      e1_q <= head_i.entry;
    end
    if (e1_adv) begin
      e2_value_q    <= x_value;
      e2_bad_q      <= x_bad;
      e2_from_mem_q <= x_from_mem;
      e2_mem_ok_q   <= mem_ok;
      e2_rwe_q      <= x_rwe;
      e2_widx_q     <= x_widx;
    end
  end

  // data memory: one access per item, in program order
  always_ff @(posedge clk_i) begin
    if (e1_adv && x_mem_we) begin
      dmem_q[mem_idx] <= x_value;
    end
    if (e1_adv && x_mem_re) begin
      mem_rdata_q <= dmem_q[mem_idx];
    end
  end

  assign out_valid_o    = e2_valid_q;
  assign result_value_o = e2_val;
  assign bad_opcode_o   = e2_bad_q;

endmodule

`default_nettype wire

// ===== rtl/four_op_register_machine_core_top.sv =====
// Four-op register machine core: front end, request queue, register file
// and execute back end. Depends on fopr_pkg and the assertion macro header.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per
//   transfer: execute instruction, host write or host read of data memory.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   per request, in request order.
//   Path: an accepted request is held in turn by the queue, the operand
//   stage and the result register, which drives the output.
//   Throughput: one request per cycle while the receiver does not
//   stall; register hazards are resolved by forwarding from the result
//   register, memory accesses occur in order in the operand stage, so
//   no bubbles are inserted.
//   Reset: queue and pipeline empty, all registers read as zero; data
//   memory contents are undefined until written.
//   Receiver stall: the result register holds; the operand stage and the
//   four-entry queue keep filling, and in_stall_o rises once the queue is
//   full.
`include "four_op_register_machine_core_top_macros.svh"
`default_nettype none

module four_op_register_machine_core_top #(
  parameter int REG_COUNT  = 16,
  parameter int DATA_WORDS = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [fopr_pkg::REQ_W-1:0]         req_type_i,
  input  wire logic [fopr_pkg::INSTR_W-1:0]       instr_word_i,
  input  wire logic [fopr_pkg::ADDR_W-1:0]        host_addr_i,
  input  wire logic signed [fopr_pkg::WORD_W-1:0] host_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [fopr_pkg::WORD_W-1:0]      result_value_o,
  output logic                                    bad_opcode_o
);
  import fopr_pkg::*;

  q_slot_t           push, head;
  logic              q_full, pop;
  rf_rd_t            rf_rd;
  rf_wr_t            rf_wr;
  logic [WORD_W-1:0] rf_a, rf_b;

  // classify requests and push them into the queue
  fopr_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .instr_word_i (instr_word_i),
    .host_addr_i  (host_addr_i),
    .host_data_i  (host_data_i),
    .q_full_i     (q_full),
    .push_o       (push)
  );

  // decouple the front end from execute stalls
  fopr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  fopr_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rf_rd),
    .wr_i   (rf_wr),
    .a_o    (rf_a),
    .b_o    (rf_b)
  );

  // execute, access data memory, drive results
  fopr_back #(
    .REG_COUNT  (REG_COUNT),
    .DATA_WORDS (DATA_WORDS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .rf_rd_o        (rf_rd),
    .rf_wr_o        (rf_wr),
    .rf_a_i         (rf_a),
    .rf_b_i         (rf_b),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .bad_opcode_o   (bad_opcode_o)
  );

  `FOPR_ASSERT_NOW(a_no_push_when_full, push.valid, !q_full, "request pushed into full queue")
  `FOPR_ASSERT_NOW(a_pop_needs_entry, pop, head.valid, "pop from empty queue")
  `FOPR_ASSERT_NEXT(a_full_holds, q_full && !pop, q_full, "queue drained without a pop")
  `FOPR_ASSERT_NOW(a_bad_zero, out_valid_o && bad_opcode_o, result_value_o == '0, "bad opcode with nonzero value")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for four_op_register_machine_core_top: directed, then random requests.
// An in-bench register/memory shadow predicts each result and compares it in order.
// Depends on fopr_pkg and the core RTL; needs no other file.
module tb_top;
  import fopr_pkg::*;

  localparam int NREG        = 16;
  localparam int NWORDS      = 256;
  localparam int RANDOM_REQS = 630;
  localparam int TAIL_REQS   = 40;   // last requests run with no idling on either side
  localparam int HOLD_AT     = 150;  // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT  = 3000; // cycles with no transfer before the watchdog fires
  localparam int DRAIN_CYCLES = 8;

  // Request type 3 carries no operation; the core answers with zeros
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
  // Opcodes outside the four that the core executes
  localparam logic [3:0] OPC_BAD_LOW  = 4'h2;
  localparam logic [3:0] OPC_BAD_HIGH = 4'hF;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [INSTR_W-1:0] instr;
    logic [ADDR_W-1:0]  addr;
    logic [WORD_W-1:0]  data;
  } host_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              bad;
  } retired_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type = '0;
  logic [INSTR_W-1:0]   instr_word = '0;
  logic [ADDR_W-1:0]    host_addr = '0;
  logic [WORD_W-1:0]    host_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [WORD_W-1:0] result_value;
  logic                 bad_opcode;

  // Shadow state of the core, advanced once per accepted request
  logic [WORD_W-1:0] reg_shadow [NREG] = '{default: '0};
  logic [WORD_W-1:0] mem_shadow [NWORDS] = '{default: '0};

  // Generator bookkeeping: which memory words a request has written so far
  bit                mem_written [NWORDS] = '{default: 1'b0};
  logic [ADDR_W-1:0] written_addrs [$];

  host_req_t req_pending_q [$];
  retired_t  retired_q [$];
  host_req_t cur_req = '0;
  logic      in_fire = 1'b0;

  int in_gap = 0;
  bit in_calm = 1'b0;
  int out_gap = 0;
  bit out_calm = 1'b0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  int results_seen = 0;
  int fail_count = 0;
  int idle_cycles = 0;

  four_op_register_machine_core_top #(
    .REG_COUNT (NREG),
    .DATA_WORDS(NWORDS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .instr_word_i  (instr_word),
    .host_addr_i   (host_addr),
    .host_data_i   (host_data),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .result_value_o(result_value),
    .bad_opcode_o  (bad_opcode)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Out-of-range register reads return zero
  function automatic logic [WORD_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
    return (int'(idx) < NREG) ? reg_shadow[idx] : '0;
  endfunction

  // Out-of-range memory reads return zero
  function automatic logic [WORD_W-1:0] mem_value(logic [ADDR_W-1:0] addr);
    return (int'(addr) < NWORDS) ? mem_shadow[addr] : '0;
  endfunction

  // Apply one request to the shadow state and return the result it retires.
  // Writes to out-of-range registers or words are dropped, but the value
  // still shows on the result.
  function automatic retired_t retire_request(host_req_t r);
    retired_t             res;
    logic [3:0]           op;
    logic [REG_IDX_W-1:0] ra, rb, rd;
    logic [ADDR_W-1:0]    maddr;
    res = '0;
    {op, ra, rb, rd} = r.instr;
    maddr = r.instr[ADDR_W-1:0];
    case (r.kind)
      REQ_EXEC: begin
        case (op)
          OPC_ADD, OPC_SUB: begin
            res.value = (op == OPC_ADD) ? reg_value(ra) + reg_value(rb)
                                        : reg_value(ra) - reg_value(rb);
            if (int'(rd) < NREG) reg_shadow[rd] = res.value;
          end
          OPC_LOAD: begin
            res.value = mem_value(maddr);
            if (int'(ra) < NREG) reg_shadow[ra] = res.value;
          end
          OPC_STORE: begin
            res.value = reg_value(ra);
            if (int'(maddr) < NWORDS) mem_shadow[maddr] = res.value;
          end
          default: res.bad = 1'b1;
        endcase
      end
      REQ_HOST_WR: begin
        res.value = r.data;
        if (int'(r.addr) < NWORDS) mem_shadow[r.addr] = r.data;
      end
      REQ_HOST_RD: res.value = mem_value(r.addr);
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue a request and note any memory word it writes, so later loads and
  // host reads only touch words that hold a defined value.
  function automatic void push_req(logic [REQ_W-1:0] kind, logic [INSTR_W-1:0] instr,
                                   logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] data);
    logic [ADDR_W-1:0] waddr;
    bit                writes;
    waddr = addr;
    writes = (kind == REQ_HOST_WR);
    if (kind == REQ_EXEC && instr[INSTR_W-1 -: 4] == OPC_STORE) begin
      waddr = instr[ADDR_W-1:0];
      writes = 1'b1;
    end
    if (writes && !mem_written[waddr]) begin
      mem_written[waddr] = 1'b1;
      written_addrs.push_back(waddr);
    end
    req_pending_q.push_back('{kind, instr, addr, data});
  endfunction

  function automatic logic [ADDR_W-1:0] pick_written();
    return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
  endfunction

  // Favor a small window of addresses so stores and loads meet often
  function automatic logic [ADDR_W-1:0] near_addr();
    return ($urandom_range(0, 1) == 0) ? ADDR_W'($urandom_range(0, 15))
                                       : ADDR_W'($urandom_range(0, NWORDS - 1));
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: sample the handshake at the rising edge, drive at the
  // falling edge. Valid drops only after a transfer, never on stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) retired_q.push_back(retire_request(cur_req));
    end
  end

  always @(negedge clk_i) begin : drive_proc
    host_req_t nxt;
    if (rst_ni && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (req_pending_q.size() > 0) begin
        nxt = req_pending_q.pop_front();
        cur_req    <= nxt;
        req_type   <= nxt.kind;
        instr_word <= nxt.instr;
        host_addr  <= nxt.addr;
        host_data  <= nxt.data;
        in_valid   <= 1'b1;
        // Plan an idle burst to follow this request; none near the end
        if (req_pending_q.size() >= TAIL_REQS && !in_calm && $urandom_range(0, 3) == 0)
          in_gap = $urandom_range(1, 12);
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts, calm stretches, and one long
  // hold-off that lets the core fill up and stall its input.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : recv_proc
    if (rst_ni) begin
      if (!pressure_done && results_seen >= HOLD_AT) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (req_pending_q.size() < TAIL_REQS) begin
        out_stall <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!out_calm && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    retired_t want;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (retired_q.size() == 0) begin
        $error("result with no request outstanding: result_value %h bad_opcode %b",
               result_value, bad_opcode);
        fail_count++;
      end else begin
        want = retired_q.pop_front();
        if (result_value !== want.value) begin
          $error("result_value: expected %h, actual %h", want.value, result_value);
          fail_count++;
        end
        if (bad_opcode !== want.bad) begin
          $error("bad_opcode: expected %b, actual %b", want.bad, bad_opcode);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus build, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned        sel;
    logic [3:0]         op;
    logic [INSTR_W-1:0] instr;

    // Preload memory with the word extremes at the address extremes
    push_req(REQ_HOST_WR, '1, 8'd0,   32'h7FFF_FFFF);
    push_req(REQ_HOST_WR, '0, 8'd255, 32'h8000_0000);
    push_req(REQ_HOST_WR, '1, 8'd1,   '1);
    push_req(REQ_HOST_RD, '0, 8'd255, '1);
    push_req(REQ_HOST_RD, '1, 8'd0,   '0);
    // Load the extremes into registers, including the highest one
    push_req(REQ_EXEC, {OPC_LOAD, 4'd1, 8'd0},   '1, '0);
    push_req(REQ_EXEC, {OPC_LOAD, 4'd2, 8'd255}, '0, '1);
    push_req(REQ_EXEC, {OPC_LOAD, 4'd15, 8'd1},  '1, '0);
    // Wrap on add and subtract, back to back so forwarding is exercised
    push_req(REQ_EXEC, {OPC_ADD, 4'd1, 4'd1, 4'd3},  '0, '0);
    push_req(REQ_EXEC, {OPC_SUB, 4'd2, 4'd1, 4'd4},  '0, '0);
    push_req(REQ_EXEC, {OPC_ADD, 4'd3, 4'd4, 4'd0},  '0, '0);
    push_req(REQ_EXEC, {OPC_SUB, 4'd0, 4'd0, 4'd5},  '0, '0);
    push_req(REQ_EXEC, {OPC_ADD, 4'd15, 4'd15, 4'd15}, '0, '0);
    push_req(REQ_EXEC, {OPC_SUB, 4'd15, 4'd15, 4'd15}, '0, '0);
    push_req(REQ_EXEC, {OPC_SUB, 4'd5, 4'd2, 4'd6},  '0, '0);
    // Store, then read the stored word straight back
    push_req(REQ_EXEC, {OPC_STORE, 4'd3, 8'h80},  '0, '0);
    push_req(REQ_EXEC, {OPC_LOAD, 4'd7, 8'h80},   '0, '0);
    push_req(REQ_HOST_RD, '0, 8'h80, '0);
    push_req(REQ_EXEC, {OPC_STORE, 4'd6, 8'd255}, '1, '1);
    push_req(REQ_HOST_RD, '1, 8'd255, '1);
    // Opcodes outside the four change nothing and raise the flag
    push_req(REQ_EXEC, {OPC_BAD_LOW, 12'hFFF},  '1, '1);
    push_req(REQ_EXEC, {OPC_BAD_HIGH, 12'hFFF}, '0, '0);
    // Request type 3 is ignored and answered with zeros
    push_req(REQ_IGNORED, '1, '1, '1);
    push_req(REQ_IGNORED, {OPC_ADD, 4'd1, 4'd1, 4'd1}, '0, '0);

    // Random part: mostly well-formed operations over a shared address window
    for (int n = 0; n < RANDOM_REQS; n++) begin
      sel = $urandom_range(0, 99);
      instr = INSTR_W'($urandom);
      if (sel < 20) begin
        push_req(REQ_HOST_WR, instr, near_addr(), pick_word());
      end else if (sel < 30) begin
        push_req(REQ_HOST_RD, instr, pick_written(), $urandom);
      end else if (sel < 55) begin
        push_req(REQ_EXEC, {OPC_ADD, instr[11:0]}, ADDR_W'($urandom), $urandom);
      end else if (sel < 70) begin
        push_req(REQ_EXEC, {OPC_SUB, instr[11:0]}, ADDR_W'($urandom), $urandom);
      end else if (sel < 82) begin
        push_req(REQ_EXEC, {OPC_LOAD, instr[11:8], pick_written()},
                 ADDR_W'($urandom), $urandom);
      end else if (sel < 92) begin
        push_req(REQ_EXEC, {OPC_STORE, instr[11:8], near_addr()},
                 ADDR_W'($urandom), $urandom);
      end else if (sel < 97) begin
        do op = 4'($urandom);
        while (op inside {OPC_ADD, OPC_SUB, OPC_LOAD, OPC_STORE});
        push_req(REQ_EXEC, {op, instr[11:0]}, ADDR_W'($urandom), $urandom);
      end else begin
        push_req(REQ_IGNORED, instr, ADDR_W'($urandom), $urandom);
      end
    end

    // Hold reset, then release it away from the rising edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Wait for every request to go in and every result to come back
    while (req_pending_q.size() > 0 || in_valid || retired_q.size() > 0)
      @(posedge clk_i);
    // Let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
